// File: hdl/hwfps_pkg.sv
// Package for the Hann-windowed FFT power spectrum unit.
// Holds the payload and command types, default sizes and the table functions
// used to build the window and twiddle ROMs. No dependencies.
package hwfps_pkg;

    localparam int WINDOW_LENGTH_DEF = 512;
    localparam int BIN_COUNT_DEF     = 256;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] sample;
        logic [7:0]         bin_select;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  bin_echo;
        logic [31:0] power;
        logic        spectrum_ready;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load;
        logic win_wr;
        logic bf_wra;
        logic bf_wrb;
        logic pw_rd;
        logic pw_out;
        logic spec_valid;
    } t_cmd;

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } t_trig;

    // Cosine and sine in Q30 of a 16-bit turn phase, by Taylor series on a quadrant.
    function automatic t_trig f_trig(input logic [15:0] t);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] cv;
        logic signed [63:0] sv;
        t_trig              res;
        quad = t[15:14];
        r    = {50'd0, t[13:0]};
        a    = (r * PI_Q30) >> 15;
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        cv   = $signed(term);
        term = ((term * a2) >> 30) / 64'd2;
        cv   = cv - $signed(term);
        term = ((term * a2) >> 30) / 64'd12;
        cv   = cv + $signed(term);
        term = ((term * a2) >> 30) / 64'd30;
        cv   = cv - $signed(term);
        term = ((term * a2) >> 30) / 64'd56;
        cv   = cv + $signed(term);
        term = ((term * a2) >> 30) / 64'd90;
        cv   = cv - $signed(term);
        term = a;
        sv   = $signed(term);
        term = ((term * a2) >> 30) / 64'd6;
        sv   = sv - $signed(term);
        term = ((term * a2) >> 30) / 64'd20;
        sv   = sv + $signed(term);
        term = ((term * a2) >> 30) / 64'd42;
        sv   = sv - $signed(term);
        term = ((term * a2) >> 30) / 64'd72;
        sv   = sv + $signed(term);
        term = ((term * a2) >> 30) / 64'd110;
        sv   = sv - $signed(term);
        case (quad)
            2'd0: begin
                res.c = cv;
                res.s = sv;
            end
            2'd1: begin
                res.c = -sv;
                res.s = cv;
            end
            2'd2: begin
                res.c = -cv;
                res.s = -sv;
            end
            default: begin
                res.c = sv;
                res.s = -cv;
            end
        endcase
        return res;
    endfunction

    function automatic logic [15:0] f_phase(input int idx, input int lg);
        logic [63:0] v;
        v = (64'(idx) << 16) >> lg;
        return v[15:0];
    endfunction

    function automatic logic [16:0] f_hann(input int idx, input int lg);
        t_trig              tr;
        logic signed [63:0] w;
        logic [16:0]        res;
        tr = f_trig(f_phase(idx, lg));
        w  = ((64'sd1 <<< 30) - tr.c + (64'sd1 <<< 15)) >>> 16;
        if (w < 0) begin
            res = 17'd0;
        end else if (w > 64'sd32768) begin
            res = 17'd32768;
        end else begin
            res = w[16:0];
        end
        return res;
    endfunction

    function automatic logic signed [16:0] f_cos_q15(input int idx, input int lg);
        t_trig              tr;
        logic signed [63:0] v;
        tr = f_trig(f_phase(idx, lg));
        v  = (tr.c + 64'sd16384) >>> 15;
        return v[16:0];
    endfunction

    function automatic logic signed [16:0] f_sin_q15(input int idx, input int lg);
        t_trig              tr;
        logic signed [63:0] v;
        tr = f_trig(f_phase(idx, lg));
        v  = (tr.s + 64'sd16384) >>> 15;
        return v[16:0];
    endfunction

    function automatic logic signed [23:0] f_sat24(input logic signed [33:0] v);
        logic signed [23:0] res;
        if (v > 34'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -34'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/hwfps_ctrl.sv
// Controller for the Hann-windowed FFT power spectrum unit.
// Sequences sample loads, windowing, butterfly passes and bin reads; uses hwfps_pkg.
module hwfps_ctrl #(
    parameter int WINDOW_LENGTH = hwfps_pkg::WINDOW_LENGTH_DEF,
    parameter int LOG2N         = $clog2(WINDOW_LENGTH),
    parameter int SW            = $clog2(LOG2N)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_mode,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hwfps_pkg::t_cmd     o_cmd,
    output logic [LOG2N-1:0]    o_load_addr,
    output logic [LOG2N-1:0]    o_idx,
    output logic [SW-1:0]       o_stage
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_WIN_RD  = 12'b0000_0000_0010,
        S_WIN_MUL = 12'b0000_0000_0100,
        S_WIN_WR  = 12'b0000_0000_1000,
        S_BF_RD   = 12'b0000_0001_0000,
        S_BF_MUL  = 12'b0000_0010_0000,
        S_BF_ADD  = 12'b0000_0100_0000,
        S_BF_WRA  = 12'b0000_1000_0000,
        S_BF_WRB  = 12'b0001_0000_0000,
        S_PW_RD   = 12'b0010_0000_0000,
        S_PW_MUL  = 12'b0100_0000_0000,
        S_PW_OUT  = 12'b1000_0000_0000
    } t_state;

    localparam logic [LOG2N-1:0] IDX_LAST  = LOG2N'(WINDOW_LENGTH - 1);
    localparam logic [LOG2N-1:0] BF_LAST   = LOG2N'(WINDOW_LENGTH / 2 - 1);
    localparam logic [SW-1:0]    STG_LAST  = SW'(LOG2N - 1);

    t_state             r_state, n_state;
    logic [LOG2N-1:0]   r_load_cnt, n_load_cnt;
    logic [LOG2N-1:0]   r_idx, n_idx;
    logic [SW-1:0]      r_stage, n_stage;
    logic               r_spec_valid, n_spec_valid;
    logic               r_out_valid, n_out_valid;
    logic               w_take;
    logic               w_out_load;

    always_comb begin
        n_state      = r_state;
        n_load_cnt   = r_load_cnt;
        n_idx        = r_idx;
        n_stage      = r_stage;
        n_spec_valid = r_spec_valid;
        w_take       = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_take = 1'b1;
                    if (i_mode == hwfps_pkg::MODE_LOAD) begin
                        if (r_load_cnt == IDX_LAST) begin
                            n_load_cnt = '0;
                            n_idx      = '0;
                            n_state    = S_WIN_RD;
                        end else begin
                            n_load_cnt = r_load_cnt + 1'b1;
                        end
                    end else begin
                        n_state = S_PW_RD;
                    end
                end
            end
            S_WIN_RD:  n_state = S_WIN_MUL;
            S_WIN_MUL: n_state = S_WIN_WR;
            S_WIN_WR: begin
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_stage = '0;
                    n_state = S_BF_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WIN_RD;
                end
            end
            S_BF_RD:  n_state = S_BF_MUL;
            S_BF_MUL: n_state = S_BF_ADD;
            S_BF_ADD: n_state = S_BF_WRA;
            S_BF_WRA: n_state = S_BF_WRB;
            S_BF_WRB: begin
                n_state = S_BF_RD;
                if (r_idx == BF_LAST) begin
                    n_idx = '0;
                    if (r_stage == STG_LAST) begin
                        n_spec_valid = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PW_RD:  n_state = S_PW_MUL;
            S_PW_MUL: n_state = S_PW_OUT;
            S_PW_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The result register frees up on a transfer and fills when a read completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_cnt   <= '0;
            r_idx        <= '0;
            r_stage      <= '0;
            r_spec_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_cnt   <= n_load_cnt;
            r_idx        <= n_idx;
            r_stage      <= n_stage;
            r_spec_valid <= n_spec_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // The bin address stays selected through the whole read so a stalled result holds.
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_load_addr       = r_load_cnt;
    assign o_idx             = r_idx;
    assign o_stage           = r_stage;
    assign o_cmd.take        = w_take;
    assign o_cmd.load        = w_take && (i_mode == hwfps_pkg::MODE_LOAD);
    assign o_cmd.win_wr      = (r_state == S_WIN_WR);
    assign o_cmd.bf_wra      = (r_state == S_BF_WRA);
    assign o_cmd.bf_wrb      = (r_state == S_BF_WRB);
    assign o_cmd.pw_rd       = (r_state == S_PW_RD) || (r_state == S_PW_MUL) ||
                               (r_state == S_PW_OUT);
    assign o_cmd.pw_out      = w_out_load;
    assign o_cmd.spec_valid  = r_spec_valid;

endmodule

// File: hdl/hwfps_datapath.sv
// Datapath for the Hann-windowed FFT power spectrum unit: sample and spectrum
// memories, window and twiddle ROMs, butterfly and power arithmetic. Uses hwfps_pkg.
module hwfps_datapath #(
    parameter int WINDOW_LENGTH = hwfps_pkg::WINDOW_LENGTH_DEF,
    parameter int BIN_COUNT     = hwfps_pkg::BIN_COUNT_DEF,
    parameter int LOG2N         = $clog2(WINDOW_LENGTH),
    parameter int SW            = $clog2(LOG2N)
) (
    input  logic                  i_clk,
    input  hwfps_pkg::t_cmd       i_cmd,
    input  hwfps_pkg::t_in_item   i_in_item,
    input  logic [LOG2N-1:0]      i_load_addr,
    input  logic [LOG2N-1:0]      i_idx,
    input  logic [SW-1:0]         i_stage,
    output hwfps_pkg::t_out_item  o_out_item
);

    localparam int HALF_N = WINDOW_LENGTH / 2;

    // ROMs built at elaboration, read through registers.
    logic [16:0]        w_hann_rom [WINDOW_LENGTH];
    logic signed [16:0] w_cos_rom  [HALF_N];
    logic signed [16:0] w_sin_rom  [HALF_N];

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_hann
        assign w_hann_rom[g] = hwfps_pkg::f_hann(g, LOG2N);
    end
    for (genvar g = 0; g < HALF_N; g++) begin : g_twid
        assign w_cos_rom[g] = hwfps_pkg::f_cos_q15(g, LOG2N);
        assign w_sin_rom[g] = hwfps_pkg::f_sin_q15(g, LOG2N);
    end

    logic signed [15:0] r_smp_mem  [WINDOW_LENGTH];
    logic [47:0]        r_spec_mem [WINDOW_LENGTH];

    logic signed [15:0] r_smp;
    logic [16:0]        r_hann;
    logic signed [33:0] r_prod;
    logic signed [16:0] r_cos;
    logic signed [16:0] r_sin;
    logic [47:0]        r_ra;
    logic [47:0]        r_rb;
    logic signed [40:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [26:0] r_tr, r_ti;
    logic [47:0]        r_bres;
    logic [46:0]        r_sq_re, r_sq_im;
    logic [7:0]         r_bin;
    hwfps_pkg::t_out_item r_out;

    // Butterfly addressing for the current stage.
    logic [LOG2N-1:0]   w_bf;
    logic [LOG2N-1:0]   w_mask;
    logic [LOG2N-1:0]   w_a_addr;
    logic [LOG2N-1:0]   w_b_addr;
    logic [LOG2N-1:0]   w_k_full;
    logic [LOG2N-2:0]   w_k;
    logic [SW-1:0]      w_ksh;
    logic [LOG2N-1:0]   w_rev;
    logic [LOG2N+7:0]   w_bin_ext;
    logic [LOG2N-1:0]   w_rd_addr;

    always_comb begin
        w_bf     = {1'b0, i_idx[LOG2N-2:0]};
        w_mask   = (LOG2N'(1) << i_stage) - LOG2N'(1);
        w_a_addr = ((w_bf & ~w_mask) << 1) | (w_bf & w_mask);
        w_b_addr = w_a_addr | (LOG2N'(1) << i_stage);
        w_ksh    = SW'(LOG2N - 1) - i_stage;
        w_k_full = (w_bf & w_mask) << w_ksh;
        w_k      = w_k_full[LOG2N-2:0];
        for (int b = 0; b < LOG2N; b++) begin
            w_rev[b] = i_idx[LOG2N-1-b];
        end
        w_bin_ext = (LOG2N+8)'(r_bin);
        w_rd_addr = i_cmd.pw_rd ? w_bin_ext[LOG2N-1:0] : w_a_addr;
    end

    // Window product rounded to Q1.23.
    logic signed [33:0] w_win_sum;
    logic signed [23:0] w_win_re;
    always_comb begin
        w_win_sum = r_prod + 34'sd64;
        w_win_re  = hwfps_pkg::f_sat24(34'($signed(w_win_sum[33:7])));
    end

    // Butterfly rotation and halved sum and difference.
    logic signed [41:0] w_tr_sum, w_ti_sum;
    logic signed [23:0] w_ar, w_ai, w_br, w_bi;
    logic signed [27:0] w_s0, w_s1, w_s2, w_s3;
    logic [47:0]        w_ares, w_bres;
    always_comb begin
        w_tr_sum = 42'(r_p0) + 42'(r_p1) + 42'sd16384;
        w_ti_sum = 42'(r_p3) - 42'(r_p2) + 42'sd16384;
        w_ar     = r_ra[47:24];
        w_ai     = r_ra[23:0];
        w_br     = r_rb[47:24];
        w_bi     = r_rb[23:0];
        w_s0     = 28'(w_ar) + 28'(r_tr) + 28'sd1;
        w_s1     = 28'(w_ai) + 28'(r_ti) + 28'sd1;
        w_s2     = 28'(w_ar) - 28'(r_tr) + 28'sd1;
        w_s3     = 28'(w_ai) - 28'(r_ti) + 28'sd1;
        w_ares   = {hwfps_pkg::f_sat24(34'($signed(w_s0[27:1]))),
                    hwfps_pkg::f_sat24(34'($signed(w_s1[27:1])))};
        w_bres   = {hwfps_pkg::f_sat24(34'($signed(w_s2[27:1]))),
                    hwfps_pkg::f_sat24(34'($signed(w_s3[27:1])))};
    end

    // Spectrum write port is shared by windowing and both butterfly outputs.
    logic               w_wr_en;
    logic [LOG2N-1:0]   w_wr_addr;
    logic [47:0]        w_wr_data;
    always_comb begin
        w_wr_en   = i_cmd.win_wr || i_cmd.bf_wra || i_cmd.bf_wrb;
        w_wr_addr = w_rev;
        w_wr_data = {w_win_re, 24'd0};
        if (i_cmd.bf_wra) begin
            w_wr_addr = w_a_addr;
            w_wr_data = w_ares;
        end else if (i_cmd.bf_wrb) begin
            w_wr_addr = w_b_addr;
            w_wr_data = r_bres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp_mem[i_load_addr] <= i_in_item.sample;
        end
        r_smp <= r_smp_mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_spec_mem[w_wr_addr] <= w_wr_data;
        end
        r_ra <= r_spec_mem[w_rd_addr];
        r_rb <= r_spec_mem[w_b_addr];
    end

    always_ff @(posedge i_clk) begin
        r_hann  <= w_hann_rom[i_idx];
        r_cos   <= w_cos_rom[w_k];
        r_sin   <= w_sin_rom[w_k];
        r_prod  <= r_smp * $signed({1'b0, r_hann});
        r_p0    <= w_br * r_cos;
        r_p1    <= w_bi * r_sin;
        r_p2    <= w_br * r_sin;
        r_p3    <= w_bi * r_cos;
        r_tr    <= w_tr_sum[41:15];
        r_ti    <= w_ti_sum[41:15];
        r_bres  <= w_bres;
        r_sq_re <= 47'(w_ar * w_ar);
        r_sq_im <= 47'(w_ai * w_ai);
        if (i_cmd.take) begin
            r_bin <= i_in_item.bin_select;
        end
    end

    // Bin 0 carries the DC term only.
    logic [47:0] w_pow_sum;
    logic        w_bin_ok;
    always_comb begin
        w_pow_sum = 48'(r_sq_re) + ((r_bin != 8'd0) ? 48'(r_sq_im) : 48'd0);
        w_bin_ok  = i_cmd.spec_valid && (32'(r_bin) < 32'(BIN_COUNT));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pw_out) begin
            r_out.bin_echo       <= r_bin;
            r_out.power          <= w_bin_ok ? w_pow_sum[47:16] : 32'd0;
            r_out.spectrum_ready <= i_cmd.spec_valid;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: hdl/hann_window_fft_power_spectrum_unit.sv
// Top level of the Hann-windowed FFT power spectrum unit.
// Joins hwfps_ctrl and hwfps_datapath; types come from hwfps_pkg.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_ready     i_in_item  (hwfps_pkg::t_in_item)
//   out      output     o_out_valid / i_out_ready   o_out_item (hwfps_pkg::t_out_item)
//
// A sample load is accepted in the idle state; the one that fills the window starts
// the transform: windowing, then the butterfly passes on the single butterfly unit,
// whose two results share the one spectrum write port. A bin read goes through the
// read, multiply and output states and lands in the output register.
// The input is taken again while a result still waits; a read only stalls when the
// output register is still full. Reset is synchronous, active low.
module hann_window_fft_power_spectrum_unit #(
    parameter int WINDOW_LENGTH = hwfps_pkg::WINDOW_LENGTH_DEF,
    parameter int BIN_COUNT     = hwfps_pkg::BIN_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hwfps_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hwfps_pkg::t_out_item  o_out_item
);

    localparam int LOG2N = $clog2(WINDOW_LENGTH);
    localparam int SW    = $clog2(LOG2N);

    hwfps_pkg::t_cmd    w_cmd;
    logic [LOG2N-1:0]   w_load_addr;
    logic [LOG2N-1:0]   w_idx;
    logic [SW-1:0]      w_stage;

    hwfps_ctrl #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .LOG2N         (LOG2N),
        .SW            (SW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_item.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .o_load_addr (w_load_addr),
        .o_idx       (w_idx),
        .o_stage     (w_stage)
    );

    hwfps_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .BIN_COUNT     (BIN_COUNT),
        .LOG2N         (LOG2N),
        .SW            (SW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_load_addr (w_load_addr),
        .i_idx       (w_idx),
        .i_stage     (w_stage),
        .o_out_item  (o_out_item)
    );

endmodule
